// ===== src/dual_stack_shared_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual stack shared buffer.
// Each check is sampled on the rising edge of clk_i and is off during reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_BUFFER_ASSERT_SVH
`define DUAL_STACK_SHARED_BUFFER_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define DSSB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dssb same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSSB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dssb next-cycle check failed");

`else

`define DSSB_ASSERT_IMP(label, ante, cons)
`define DSSB_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/dssb_pkg.sv =====
// ----------------------------------------------------------------------------
// dssb_pkg
// Types and codes shared by the dual stack shared buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dssb_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_PUSH_LOWER = 2'd0,
    OP_POP_LOWER  = 2'd1,
    OP_PUSH_UPPER = 2'd2,
    OP_POP_UPPER  = 2'd3
  } opcode_e;

  // Status codes carried by a result item.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_RESP = 2'd3
  } state_e;

  localparam int unsigned WordWidth = 32;

  // Value returned by a pop from an empty stack.
  localparam logic [WordWidth-1:0] EmptyWord = '1;

  typedef struct packed {
    opcode_e                     opcode;
    logic signed [WordWidth-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] pop_value;
    status_e                     status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // Latch the accepted item.
    logic exec;       // Run the latched operation.
    logic load_read;  // Take the memory read data as the result.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;  // The latched operation is a pop from a non-empty stack.
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/dssb_ram.sv =====
// ----------------------------------------------------------------------------
// dssb_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dssb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One address per cycle, used by a write, a registered read, or both.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/dssb_datapath.sv =====
// ----------------------------------------------------------------------------
// dssb_datapath
// Stack counters, address generation, the shared buffer and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dssb_datapath #(
  parameter int unsigned Depth = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dssb_pkg::in_item_t   in_item_i,
  input  wire dssb_pkg::dp_cmd_t    cmd_i,
  output      dssb_pkg::dp_status_t status_o,
  output      dssb_pkg::out_item_t  out_item_o
);

  localparam int unsigned AddrWidth  = $clog2(Depth);
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  localparam logic [CountWidth-1:0] DepthCount = CountWidth'(Depth);
  localparam logic [CountWidth-1:0] LastCount  = CountWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] OneCount   = CountWidth'(1);

  dssb_pkg::in_item_t  item_q;
  dssb_pkg::out_item_t res_q, res_d;
  logic [CountWidth-1:0] lower_q, lower_d;
  logic [CountWidth-1:0] upper_q, upper_d;

  logic                                 buf_full;
  logic                                 lower_empty;
  logic                                 upper_empty;
  logic [CountWidth:0]                  total;
  logic [CountWidth-1:0]                addr_wide;
  logic                                 ram_we;
  logic                                 ram_re;
  logic [dssb_pkg::WordWidth-1:0]       ram_rdata;

  // The accepted item is held for the whole operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // Occupancy flags.
  assign total       = {1'b0, lower_q} + {1'b0, upper_q};
  assign buf_full    = total >= {1'b0, DepthCount};
  assign lower_empty = lower_q == '0;
  assign upper_empty = upper_q == '0;

  assign status_o.need_read =
      ((item_q.opcode == dssb_pkg::OP_POP_LOWER) && !lower_empty) ||
      ((item_q.opcode == dssb_pkg::OP_POP_UPPER) && !upper_empty);

  // Operation decode: memory access, counter update and result.
  always_comb begin
    lower_d   = lower_q;
    upper_d   = upper_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    addr_wide = lower_q;
    case (item_q.opcode)
      dssb_pkg::OP_PUSH_LOWER: addr_wide = lower_q;
      dssb_pkg::OP_POP_LOWER:  addr_wide = lower_q - OneCount;
      dssb_pkg::OP_PUSH_UPPER: addr_wide = LastCount - upper_q;
      dssb_pkg::OP_POP_UPPER:  addr_wide = DepthCount - upper_q;
      default:                 addr_wide = lower_q;
    endcase
    if (cmd_i.exec) begin
      case (item_q.opcode)
        dssb_pkg::OP_PUSH_LOWER: begin
          if (buf_full) begin
            res_d = '{pop_value: '0, status: dssb_pkg::ST_FULL};
          end else begin
            ram_we  = 1'b1;
            lower_d = lower_q + OneCount;
            res_d   = '{pop_value: '0, status: dssb_pkg::ST_DONE};
          end
        end
        dssb_pkg::OP_PUSH_UPPER: begin
          if (buf_full) begin
            res_d = '{pop_value: '0, status: dssb_pkg::ST_FULL};
          end else begin
            ram_we  = 1'b1;
            upper_d = upper_q + OneCount;
            res_d   = '{pop_value: '0, status: dssb_pkg::ST_DONE};
          end
        end
        dssb_pkg::OP_POP_LOWER: begin
          if (lower_empty) begin
            res_d = '{pop_value: dssb_pkg::EmptyWord, status: dssb_pkg::ST_EMPTY};
          end else begin
            ram_re  = 1'b1;
            lower_d = lower_q - OneCount;
          end
        end
        default: begin
          if (upper_empty) begin
            res_d = '{pop_value: dssb_pkg::EmptyWord, status: dssb_pkg::ST_EMPTY};
          end else begin
            ram_re  = 1'b1;
            upper_d = upper_q - OneCount;
          end
        end
      endcase
    end
    if (cmd_i.load_read) begin
      res_d = '{pop_value: ram_rdata, status: dssb_pkg::ST_DONE};
    end
  end

  // Stack counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
    end else begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_item_o = res_q;

  // Shared buffer for both stacks.
  dssb_ram #(
    .Width (dssb_pkg::WordWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (addr_wide[AddrWidth-1:0]),
    .wdata_i (item_q.push_value),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== src/dssb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dssb_ctrl
// Controller state machine: sequences one item through execute, a read state
// for pops that read the buffer, and response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dssb_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 out_ready_i,
  input  wire dssb_pkg::dp_status_t status_i,
  output      logic                 in_ready_o,
  output      logic                 out_valid_o,
  output      dssb_pkg::dp_cmd_t    cmd_o
);

  dssb_pkg::state_e state_q, state_d;
  logic             accept;

  // A new item is taken when idle, or as the pending result leaves.
  assign in_ready_o = (state_q == dssb_pkg::S_IDLE) ||
                      ((state_q == dssb_pkg::S_RESP) && out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dssb_pkg::S_IDLE: begin
        if (accept) state_d = dssb_pkg::S_EXEC;
      end
      dssb_pkg::S_EXEC: begin
        state_d = status_i.need_read ? dssb_pkg::S_READ : dssb_pkg::S_RESP;
      end
      dssb_pkg::S_READ: begin
        state_d = dssb_pkg::S_RESP;
      end
      dssb_pkg::S_RESP: begin
        if (out_ready_i) begin
          state_d = accept ? dssb_pkg::S_EXEC : dssb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dssb_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    out_valid_o = 1'b0;
    cmd_o.capture = accept;
    case (state_q)
      dssb_pkg::S_EXEC: cmd_o.exec      = 1'b1;
      dssb_pkg::S_READ: cmd_o.load_read = 1'b1;
      dssb_pkg::S_RESP: out_valid_o     = 1'b1;
      default: begin
        out_valid_o = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dssb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/dual_stack_shared_buffer.sv =====
// Two LIFO stacks share one buffer of DEPTH 32-bit words: the lower stack
// grows up from entry 0, the upper stack grows down from the last entry, and
// a push is dropped with status FULL once the stacks together hold DEPTH
// words. A pop from an empty stack returns -1 with status EMPTY. Every item
// gives exactly one result. Items are handled one at a time: a push or a pop
// from an empty stack runs through the execute and response states, and a
// pop that reads the buffer has a read state between them for the registered
// read of the single-port buffer memory. A new item is accepted in the cycle
// its predecessor's result is taken, so the block never takes a new item
// while the one before it is still in execute or read. The buffer contents
// are not cleared at reset; only the stack counters and controller state are.
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer
// Top level: controller and datapath for two stacks in one shared buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_stack_shared_buffer_assert.svh"

module dual_stack_shared_buffer #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire dssb_pkg::in_item_t  in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      dssb_pkg::out_item_t out_item_o
);

  dssb_pkg::dp_cmd_t    cmd;
  dssb_pkg::dp_status_t dp_status;

  dssb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  dssb_datapath #(
    .Depth (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (dp_status),
    .out_item_o (out_item_o)
  );

  // A dropped push always reports a zero word.
  `DSSB_ASSERT_IMP(a_full_zero, out_valid_o && (out_item_o.status == dssb_pkg::ST_FULL), out_item_o.pop_value == '0)
  // An empty pop always reports all ones.
  `DSSB_ASSERT_IMP(a_empty_ones, out_valid_o && (out_item_o.status == dssb_pkg::ST_EMPTY), out_item_o.pop_value == dssb_pkg::EmptyWord)
  // No result is shown in the cycle right after an item is taken.
  `DSSB_ASSERT_NXT(a_no_early_result, in_valid_i && in_ready_o, !out_valid_o)
  // A waiting result blocks new items until it is taken.
  `DSSB_ASSERT_IMP(a_hold_blocks_input, out_valid_o && !out_ready_i, !in_ready_o)

endmodule

`default_nettype wire

// ===== test/dssb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssb_checker
// Watches both channels of the dual stack shared buffer. Every accepted input
// item runs through a local model of the two stacks. Every accepted result is
// compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module dssb_checker #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  dssb_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  dssb_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  lower_level_o,
  output int                  upper_level_o,
  output int                  checked_count_o,
  output int                  drop_count_o,
  output int                  empty_count_o
);
  import dssb_pkg::*;

  // Local copy of the shared buffer and the two stack depths.
  logic [WordWidth-1:0] stack_words [DEPTH];
  int unsigned          lower_depth;
  int unsigned          upper_depth;
  out_item_t            expected_q [$];

  // Applies one operation to the local stacks and returns its result.
  function automatic out_item_t apply_op(input in_item_t item);
    out_item_t   res;
    int unsigned slot;
    res.pop_value = '0;
    res.status    = ST_DONE;
    case (item.opcode)
      OP_PUSH_LOWER: begin
        if (lower_depth + upper_depth >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_words[lower_depth] = item.push_value;
          lower_depth++;
        end
      end
      OP_POP_LOWER: begin
        if (lower_depth == 0) begin
          res.pop_value = EmptyWord;
          res.status    = ST_EMPTY;
        end else begin
          lower_depth--;
          res.pop_value = stack_words[lower_depth];
        end
      end
      OP_PUSH_UPPER: begin
        if (lower_depth + upper_depth >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = DEPTH - 1 - upper_depth;
          stack_words[slot] = item.push_value;
          upper_depth++;
        end
      end
      default: begin
        if (upper_depth == 0) begin
          res.pop_value = EmptyWord;
          res.status    = ST_EMPTY;
        end else begin
          slot = DEPTH - upper_depth;
          res.pop_value = stack_words[slot];
          upper_depth--;
        end
      end
    endcase
    return res;
  endfunction

  // Compare results first, then record the expectation of a new item.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      expected_q.delete();
      lower_depth     = 0;
      upper_depth     = 0;
      fail_count_o    = 0;
      checked_count_o = 0;
      drop_count_o    = 0;
      empty_count_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_item_i;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got pop_value %h status %0d",
                   $time, got.pop_value, got.status);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_count_o++;
          if (got.pop_value !== want.pop_value) begin
            $display("%0t: pop_value mismatch, expected %h, got %h",
                     $time, want.pop_value, got.pop_value);
            fail_count_o++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = apply_op(in_item_i);
        if (want.status == ST_FULL) drop_count_o++;
        if (want.status == ST_EMPTY) empty_count_o++;
        expected_q.push_back(want);
      end
    end
    pending_o     = expected_q.size();
    lower_level_o = lower_depth;
    upper_level_o = upper_depth;
  end

endmodule

// ===== test/tb_dual_stack_shared_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_stack_shared_buffer
// Drives stack operations into the dual stack shared buffer: a directed set of
// edge cases, then random fill, drain and mixed sequences with random gaps on
// both sides. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_dual_stack_shared_buffer;
  import dssb_pkg::*;

  localparam int unsigned DEPTH          = 128;
  localparam int          TargetItems    = 520;
  localparam int          LongHoldAt     = 60;
  localparam int          LongHoldCycles = 400;
  localparam int          SettleCycles   = 10;

  // Which stack a random operation goes to.
  typedef enum int {
    SIDE_MIXED,
    SIDE_LOWER,
    SIDE_UPPER
  } side_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  int fail_count;
  int pending;
  int lower_level;
  int upper_level;
  int checked_count;
  int drop_count;
  int empty_count;
  int items_sent;
  int send_quiet;
  int recv_quiet;

  dual_stack_shared_buffer #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  dssb_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_item_i      (in_item_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_i     (out_item_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .lower_level_o  (lower_level),
    .upper_level_o  (upper_level),
    .checked_count_o(checked_count),
    .drop_count_o   (drop_count),
    .empty_count_o  (empty_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Draws a random idle gap, with occasional stretches of none.
  task automatic draw_gap(inout int quiet_left, output int gap);
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(10, 40);
    end
  endtask

  // Picks a push or a pop on the lower or the upper stack.
  function automatic opcode_e choose_op(input bit is_push, input side_e side);
    bit use_lower;
    use_lower = (side == SIDE_LOWER) || (side == SIDE_MIXED && $urandom_range(0, 1) == 1);
    if (is_push) return use_lower ? OP_PUSH_LOWER : OP_PUSH_UPPER;
    return use_lower ? OP_POP_LOWER : OP_POP_UPPER;
  endfunction

  // Offers one item after a random gap. Called and returns at a falling edge.
  task automatic send_item(input opcode_e op, input logic [WordWidth-1:0] value);
    int gap;
    draw_gap(send_quiet, gap);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i.opcode     = op;
    in_item_i.push_value = value;
    in_valid_i           = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering items until every expected result has been taken.
  task automatic pause_sender();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mostly pushes until the buffer is full, then a few pushes that get dropped.
  task automatic run_fill(input side_e side);
    int extra;
    while (lower_level + upper_level < DEPTH) begin
      send_item(choose_op($urandom_range(0, 9) != 0, side), $urandom());
    end
    send_item(OP_PUSH_LOWER, $urandom());
    send_item(OP_PUSH_UPPER, $urandom());
    extra = $urandom_range(0, 3);
    repeat (extra) send_item(choose_op(1'b1, SIDE_MIXED), $urandom());
  endtask

  // Mostly pops from non-empty stacks until both are empty, then two more.
  task automatic run_drain();
    opcode_e op;
    while (lower_level != 0 || upper_level != 0) begin
      if ($urandom_range(0, 9) == 0) op = choose_op(1'b1, SIDE_MIXED);
      else if (lower_level == 0) op = OP_POP_UPPER;
      else if (upper_level == 0) op = OP_POP_LOWER;
      else op = choose_op(1'b0, SIDE_MIXED);
      send_item(op, $urandom());
    end
    send_item(OP_POP_LOWER, $urandom());
    send_item(OP_POP_UPPER, $urandom());
  endtask

  // Uniformly random operations and values.
  task automatic run_mixed(input int count);
    repeat (count) send_item(opcode_e'($urandom_range(0, 3)), $urandom());
  endtask

  // Result side: random stalls, and one long hold-off while items keep coming.
  initial begin
    int gap;
    int taken;
    out_ready_i = 1'b0;
    recv_quiet  = 0;
    taken       = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      draw_gap(recv_quiet, gap);
      if (taken == LongHoldAt) gap = LongHoldCycles;
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    items_sent = 0;
    send_quiet = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty pops on both sides, extreme words through both stacks, then
    // pops past the bottom of each stack.
    send_item(OP_POP_LOWER, 32'h0000_0000);
    send_item(OP_POP_UPPER, 32'hFFFF_FFFF);
    send_item(OP_PUSH_LOWER, 32'h7FFF_FFFF);
    send_item(OP_PUSH_LOWER, 32'h8000_0000);
    send_item(OP_PUSH_UPPER, 32'hFFFF_FFFF);
    send_item(OP_PUSH_UPPER, 32'h0000_0000);
    send_item(OP_PUSH_LOWER, 32'h5A5A_5A5A);
    send_item(OP_PUSH_UPPER, 32'hA5A5_A5A5);
    send_item(OP_POP_UPPER, 32'h1234_5678);
    send_item(OP_POP_UPPER, 32'h0000_0000);
    send_item(OP_POP_UPPER, 32'hFFFF_FFFF);
    send_item(OP_POP_UPPER, 32'h0000_0000);
    send_item(OP_POP_LOWER, 32'hFFFF_FFFF);
    send_item(OP_POP_LOWER, 32'h0000_0000);
    send_item(OP_POP_LOWER, 32'h8765_4321);
    send_item(OP_POP_LOWER, 32'h0000_0000);
    pause_sender();

    // Fill from both ends until the stacks meet, mix in random traffic, then drain everything.
    run_fill(SIDE_MIXED);
    run_mixed(30);
    run_drain();
    pause_sender();

    // Let the lower stack take the whole buffer, then random traffic.
    run_fill(SIDE_LOWER);
    while (items_sent < TargetItems) run_mixed(1);

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    $display("Ran %0d items, %0d results checked, with the buffer filled from both ends",
             items_sent, checked_count);
    $display("and from one end: %0d pushes dropped on a full buffer, %0d pops from empty",
             drop_count, empty_count);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule
